// File: design/gihd_pkg.sv
// ----------------------------------------------------------------------------
// gihd_pkg
// Shared types and constants of the 2x2 half downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package gihd_pkg;

	localparam int unsigned PixW    = 8;
	localparam int unsigned PairW   = 9;
	localparam int unsigned CfgW    = 12;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 2'd1;

	localparam logic [CfgW-1:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [CfgW-1:0] FRAME_HEIGHT_RST = 12'd480;

	// raster position of the pixel on the input port
	typedef struct packed {
		logic col_odd;
		logic row_odd;
		logic last;
		logic ok;
	} gihd_pos_t;

endpackage

`default_nettype wire

// File: design/gihd_in_if.sv
// ----------------------------------------------------------------------------
// gihd_in_if
// Pixel input channel: valid/ready with one grayscale pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface gihd_in_if;
	logic                       valid;
	logic                       ready;
	logic [gihd_pkg::PixW-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

// File: design/gihd_out_if.sv
// ----------------------------------------------------------------------------
// gihd_out_if
// Result channel: valid/ready with one downsampled pixel and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface gihd_out_if;
	logic                       valid;
	logic                       ready;
	logic [gihd_pkg::PixW-1:0] pixel_out;
	logic                       frame_last;
	logic                       rejected;

	modport source (output valid, output pixel_out, output frame_last, output rejected,
		input ready);
	modport sink (input valid, input pixel_out, input frame_last, input rejected,
		output ready);
endinterface

`default_nettype wire

// File: design/gihd_line_store.sv
// ----------------------------------------------------------------------------
// gihd_line_store
// One-write one-read line memory of pair sums, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gihd_line_store #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [AW-1:0]                 waddr,
	input  wire logic [gihd_pkg::PairW-1:0]   wdata,
	input  wire logic                          re,
	input  wire logic [AW-1:0]                 raddr,
	output      logic [gihd_pkg::PairW-1:0]   rdata
);

	logic [gihd_pkg::PairW-1:0] mem [DEPTH];
	logic [gihd_pkg::PairW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: design/gihd_raster.sv
// ----------------------------------------------------------------------------
// gihd_raster
// Frame size registers and column/row counters of the input raster.
// ----------------------------------------------------------------------------
`default_nettype none

module gihd_raster #(
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned MAX_HEIGHT = 2048,
	parameter int unsigned CW         = 11,
	parameter int unsigned RW         = 11
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [gihd_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [gihd_pkg::CfgW-1:0]      cfg_data,
	input  wire logic                            step,
	output      gihd_pkg::gihd_pos_t            pos,
	output      logic [CW-1:0]                   col
);

	localparam int unsigned CmpWW = (gihd_pkg::CfgW > CW + 1) ? gihd_pkg::CfgW : CW + 1;
	localparam int unsigned CmpHW = (gihd_pkg::CfgW > RW + 1) ? gihd_pkg::CfgW : RW + 1;

	logic [gihd_pkg::CfgW-1:0] frame_width_q;
	logic [gihd_pkg::CfgW-1:0] frame_height_q;
	logic [CW-1:0]             col_q;
	logic [RW-1:0]             row_q;

	logic [CmpWW-1:0] fw_ext;
	logic [CmpHW-1:0] fh_ext;
	logic             w_zero, w_over, h_zero, h_over;
	logic [CW-1:0]    w_last_col;
	logic [RW-1:0]    h_last_row;
	logic             at_last_col, at_last_row;

	always_comb begin
		fw_ext = CmpWW'(frame_width_q);
		fh_ext = CmpHW'(frame_height_q);
		w_zero = (frame_width_q == '0);
		h_zero = (frame_height_q == '0);
		w_over = fw_ext > CmpWW'(MAX_WIDTH);
		h_over = fh_ext > CmpHW'(MAX_HEIGHT);
		// clamp to 1 .. max for counting
		if (w_zero) begin
			w_last_col = '0;
		end else if (w_over) begin
			w_last_col = CW'(MAX_WIDTH - 1);
		end else begin
			w_last_col = CW'(fw_ext - CmpWW'(1));
		end
		if (h_zero) begin
			h_last_row = '0;
		end else if (h_over) begin
			h_last_row = RW'(MAX_HEIGHT - 1);
		end else begin
			h_last_row = RW'(fh_ext - CmpHW'(1));
		end
		at_last_col = (col_q == w_last_col);
		at_last_row = (row_q == h_last_row);
		pos.col_odd = col_q[0];
		pos.row_odd = row_q[0];
		pos.last    = at_last_col && at_last_row;
		pos.ok      = !w_zero && !w_over && !frame_width_q[0]
			&& !h_zero && !h_over && !frame_height_q[0];
	end

	assign col = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= gihd_pkg::FRAME_WIDTH_RST;
			frame_height_q <= gihd_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			if (cfg_index == gihd_pkg::CFG_FRAME_WIDTH) begin
				frame_width_q <= cfg_data;
			end
			if (cfg_index == gihd_pkg::CFG_FRAME_HEIGHT) begin
				frame_height_q <= cfg_data;
			end
		end
	end

	// any register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (at_last_col) begin
				col_q <= '0;
				row_q <= at_last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: design/gray_image_half_downsample_unit.sv
// Latency: a result is valid in the cycle after the odd-row, odd-column request.
// Throughput: one pixel per cycle unless the output register holds an untaken result;
//   the line store is written on odd columns of even rows and read on even columns
//   of odd rows, and the output register frees itself whenever the result is taken.
// Reset: counters zero, frame size 640 x 480; the line store is not cleared,
//   each entry is written on the even row before the odd row reads it.
// ----------------------------------------------------------------------------
// gray_image_half_downsample_unit
// 2x2 box filter that halves a raster grayscale frame in both directions.
// ----------------------------------------------------------------------------
`default_nettype none

module gray_image_half_downsample_unit #(
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned MAX_HEIGHT = 2048
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	gihd_in_if.sink                            pixels,
	gihd_out_if.source                         results,
	input  wire logic                          cfg_we,
	input  wire logic [gihd_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [gihd_pkg::CfgW-1:0]    cfg_data
);

	localparam int unsigned CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned RW    = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned DEPTH = MAX_WIDTH / 2;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned SumW  = gihd_pkg::PairW + 1;

	gihd_pkg::gihd_pos_t            pos;
	logic [CW-1:0]                  col;
	logic [AW-1:0]                  slot;
	logic                           accept;
	logic                           mem_we, mem_re;
	logic [gihd_pkg::PairW-1:0]    mem_wdata, mem_rdata;
	logic [gihd_pkg::PixW-1:0]     pair_left_q;
	logic [SumW-1:0]                total;
	logic                           produce;

	logic                           out_valid_q;
	logic [gihd_pkg::PixW-1:0]     pixel_out_q;
	logic                           frame_last_q;
	logic                           rejected_q;

	gihd_raster #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CW         (CW),
		.RW         (RW)
	) u_raster (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (accept),
		.pos       (pos),
		.col       (col)
	);

	gihd_line_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_line_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (slot),
		.rdata (mem_rdata)
	);

	assign pixels.ready = !out_valid_q || results.ready;
	assign accept       = pixels.valid && pixels.ready;
	assign slot         = AW'(col >> 1);

	always_comb begin
		mem_we    = accept && pos.ok && pos.col_odd && !pos.row_odd;
		// fetch the pair above while the left pixel of the lower pair arrives
		mem_re    = accept && pos.ok && !pos.col_odd && pos.row_odd;
		mem_wdata = gihd_pkg::PairW'(pair_left_q) + gihd_pkg::PairW'(pixels.pixel_in);
		total     = SumW'(mem_rdata) + SumW'(pair_left_q) + SumW'(pixels.pixel_in);
		produce   = pos.ok ? (pos.col_odd && pos.row_odd) : pos.last;
	end

	always_ff @(posedge clk) begin
		if (accept && !pos.col_odd) begin
			pair_left_q <= pixels.pixel_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= produce;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && produce) begin
			pixel_out_q  <= pos.ok ? total[SumW-1:2] : '0;
			frame_last_q <= pos.last;
			rejected_q   <= !pos.ok;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.pixel_out  = pixel_out_q;
	assign results.frame_last = frame_last_q;
	assign results.rejected   = rejected_q;

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2x2 half downsampler. Frames of random pixels
// go in under several geometries, odd, zero and oversized ones among them.
// Each block mean is predicted as its request is taken and compared with
// the result stream, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned MAX_W          = 2048;
	localparam int unsigned MAX_H          = 2048;
	localparam int unsigned STORE_DEPTH    = MAX_W / 2;
	localparam int unsigned SUM_W          = gihd_pkg::PairW + 1;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned PARTIAL_PIXELS = 40;
	localparam int unsigned TIMEOUT_NS     = 2_000_000;

	// indexes past the register list: no register changes, the frame restarts
	localparam logic [gihd_pkg::CfgIdxW-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [gihd_pkg::CfgIdxW-1:0] CFG_SPARE_3 = 2'd3;

	typedef struct packed {
		logic [gihd_pkg::PixW-1:0] pixel_out;
		logic                      frame_last;
		logic                      rejected;
	} down_pixel_t;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         cfg_we    = 1'b0;
	logic [gihd_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [gihd_pkg::CfgW-1:0]    cfg_data  = '0;

	gihd_in_if  pix_if ();
	gihd_out_if res_if ();

	gray_image_half_downsample_unit #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pix_if),
		.results   (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predicted state of the block
	logic [gihd_pkg::CfgW-1:0]  frame_width  = gihd_pkg::FRAME_WIDTH_RST;
	logic [gihd_pkg::CfgW-1:0]  frame_height = gihd_pkg::FRAME_HEIGHT_RST;
	logic [gihd_pkg::PairW-1:0] line_sums [STORE_DEPTH];
	logic [gihd_pkg::PixW-1:0]  left_pixel   = '0;
	logic [10:0]                col_pos      = '0;
	logic [10:0]                row_pos      = '0;
	down_pixel_t                pending_means [$];

	int unsigned send_idle_pct   = 37;
	int unsigned recv_idle_pct   = 46;
	bit          hold_request    = 1'b0;
	int unsigned hold_len        = 0;
	int unsigned pixels_sent     = 0;
	int unsigned results_checked = 0;
	int unsigned rejects_seen    = 0;
	int unsigned failures        = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int unsigned span_of_dim(logic [gihd_pkg::CfgW-1:0] dim,
			int unsigned lim);
		if (dim == 0) return 1;
		if (dim > lim) return lim;
		return 32'(dim);
	endfunction

	function automatic bit dim_usable(logic [gihd_pkg::CfgW-1:0] dim, int unsigned lim);
		return dim != 0 && dim <= lim && !dim[0];
	endfunction

	function automatic int unsigned frame_pixels();
		return span_of_dim(frame_width, MAX_W) * span_of_dim(frame_height, MAX_H);
	endfunction

	task automatic downsample_pixel(input logic [gihd_pkg::PixW-1:0] px);
		int unsigned      w;
		int unsigned      h;
		bit               usable;
		bit               last_col;
		bit               last_pix;
		logic [SUM_W-1:0] total;
		w        = span_of_dim(frame_width, MAX_W);
		h        = span_of_dim(frame_height, MAX_H);
		usable   = dim_usable(frame_width, MAX_W) && dim_usable(frame_height, MAX_H);
		last_col = (col_pos + 1 >= w);
		last_pix = last_col && (row_pos + 1 >= h);
		if (usable) begin
			if (!col_pos[0]) begin
				left_pixel = px;
			end else if (!row_pos[0]) begin
				line_sums[col_pos[10:1]] = gihd_pkg::PairW'(left_pixel)
					+ gihd_pkg::PairW'(px);
			end else begin
				total = SUM_W'(line_sums[col_pos[10:1]]) + SUM_W'(left_pixel) + SUM_W'(px);
				pending_means.push_back('{pixel_out: total[SUM_W-1:2], frame_last: last_pix,
					rejected: 1'b0});
			end
		end else if (last_pix) begin
			pending_means.push_back('{pixel_out: '0, frame_last: 1'b1, rejected: 1'b1});
		end
		if (last_pix) begin
			col_pos = '0;
			row_pos = '0;
		end else if (last_col) begin
			col_pos = '0;
			row_pos = row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
	endtask

	// receiver: random ready, or a held-off stretch on request
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = hold_len;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		down_pixel_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_means.size() == 0) begin
				$error("unrequested result: pixel_out %0d frame_last %0b rejected %0b",
					res_if.pixel_out, res_if.frame_last, res_if.rejected);
				failures++;
			end else begin
				want = pending_means.pop_front();
				results_checked++;
				if (res_if.rejected === 1'b1) rejects_seen++;
				if (res_if.pixel_out !== want.pixel_out) begin
					$error("pixel_out: expected %0d, got %0d", want.pixel_out, res_if.pixel_out);
					failures++;
				end
				if (res_if.frame_last !== want.frame_last) begin
					$error("frame_last: expected %0b, got %0b", want.frame_last,
						res_if.frame_last);
					failures++;
				end
				if (res_if.rejected !== want.rejected) begin
					$error("rejected: expected %0b, got %0b", want.rejected, res_if.rejected);
					failures++;
				end
			end
		end
	end

	// called on a clock edge; returns on the edge the request is taken
	task automatic send_pixel(input logic [gihd_pkg::PixW-1:0] px);
		if ($urandom_range(99) < send_idle_pct) begin
			pix_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		pix_if.valid    <= 1'b1;
		pix_if.pixel_in <= px;
		do @(posedge clk); while (!pix_if.ready);
		pixels_sent++;
		downsample_pixel(px);
	endtask

	task automatic send_frame(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_pixel(gihd_pkg::PixW'($urandom_range(255)));
	endtask

	// block must be drained before any register write
	task automatic wait_idle();
		pix_if.valid <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [gihd_pkg::CfgIdxW-1:0] idx, input int unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= gihd_pkg::CfgW'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			gihd_pkg::CFG_FRAME_WIDTH:  frame_width  = gihd_pkg::CfgW'(val);
			gihd_pkg::CFG_FRAME_HEIGHT: frame_height = gihd_pkg::CfgW'(val);
			default: ;
		endcase
		col_pos = '0;
		row_pos = '0;
		@(posedge clk);
	endtask

	task automatic set_frame(input int unsigned w, input int unsigned h);
		if ($urandom_range(1)) begin
			write_reg(gihd_pkg::CFG_FRAME_WIDTH, w);
			write_reg(gihd_pkg::CFG_FRAME_HEIGHT, h);
		end else begin
			write_reg(gihd_pkg::CFG_FRAME_HEIGHT, h);
			write_reg(gihd_pkg::CFG_FRAME_WIDTH, w);
		end
	endtask

	// 640 x 480 out of reset; a spare-index write mid-row must restart the frame
	task automatic test_reset_geometry();
		send_frame(10);
		wait_idle();
		write_reg(CFG_SPARE_2, 4095);
		send_frame(6);
	endtask

	task automatic test_block_means();
		logic [gihd_pkg::PixW-1:0] corner_rows [16];
		logic [gihd_pkg::PixW-1:0] smallest [4];
		corner_rows = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255,
			8'd255, 8'd254, 8'd1, 8'd2, 8'd255, 8'd255, 8'd0, 8'd0};
		smallest = '{8'd128, 8'd127, 8'd64, 8'd63};
		wait_idle();
		set_frame(4, 2);
		foreach (corner_rows[i]) send_pixel(corner_rows[i]);
		wait_idle();
		set_frame(2, 2);
		foreach (smallest[i]) send_pixel(smallest[i]);
	endtask

	task automatic test_frame_restart();
		wait_idle();
		set_frame(6, 4);
		send_frame(9);
		wait_idle();
		write_reg(gihd_pkg::CFG_FRAME_WIDTH, 6);
		send_frame(24);
	endtask

	task automatic test_rejected_sizes();
		int unsigned odd_dims [9][2];
		int unsigned n;
		odd_dims = '{'{3, 2}, '{4, 3}, '{0, 4}, '{6, 0}, '{2, 1}, '{1, 1},
			'{4095, 1}, '{2049, 1}, '{1, 4095}};
		foreach (odd_dims[i]) begin
			wait_idle();
			set_frame(odd_dims[i][0], odd_dims[i][1]);
			n = frame_pixels();
			// clamped huge frames: only their start, the next write restarts them
			if (n > PARTIAL_PIXELS)
				send_frame(PARTIAL_PIXELS);
			else
				send_frame(2 * n);
		end
	endtask

	// start of the widest and of the tallest frame
	task automatic test_extreme_sizes();
		wait_idle();
		set_frame(MAX_W, 2);
		send_frame(PARTIAL_PIXELS);
		wait_idle();
		set_frame(2, MAX_H);
		send_frame(PARTIAL_PIXELS);
	endtask

	// long receiver hold-off while requests keep coming: input must back up
	task automatic test_output_stall();
		wait_idle();
		set_frame(16, 8);
		hold_len     = 400;
		hold_request = 1'b1;
		send_frame(frame_pixels());
	endtask

	task automatic test_random_frames(input int unsigned s_pct, input int unsigned r_pct,
			input int unsigned pixel_budget);
		int unsigned first;
		int unsigned w;
		int unsigned h;
		int unsigned n;
		int unsigned pick;
		int unsigned frames;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		first         = pixels_sent;
		while (pixels_sent - first < pixel_budget) begin
			pick = $urandom_range(99);
			if (pick < 82) begin
				w = 2 * $urandom_range(1, 6);
				h = 2 * $urandom_range(1, 3);
			end else if (pick < 94) begin
				w = $urandom_range(1, 7);
				h = $urandom_range(1, 5);
			end else if (pick < 97) begin
				w = 0;
				h = $urandom_range(0, 6);
			end else begin
				w = $urandom_range(1, 6);
				h = 0;
			end
			wait_idle();
			set_frame(w, h);
			if ($urandom_range(4) == 0)
				write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom_range(4095));
			n      = frame_pixels();
			frames = 1 + $urandom_range(1);
			// now and then cut the last frame short; the next write restarts it
			if ($urandom_range(9) == 0)
				send_frame(n * frames - $urandom_range(1, n));
			else
				send_frame(n * frames);
		end
	endtask

	initial begin
		pix_if.valid    <= 1'b0;
		pix_if.pixel_in <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_geometry();
		test_block_means();
		test_frame_restart();
		test_rejected_sizes();
		test_extreme_sizes();
		test_output_stall();
		test_random_frames(37, 46, 110);
		test_random_frames(46, 37, 110);
		test_random_frames(0, 0, 110);
		wait_idle();
		repeat (16) @(posedge clk);
		$display("Summary: %0d pixels sent, %0d results checked (%0d rejected frames).",
			pixels_sent, results_checked, rejects_seen);
		$display("Covered: reset size, block means, restarts, odd/zero/oversized sizes, stall.");
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: gray_image_half_downsample_unit.f
design/gihd_pkg.sv
design/gihd_in_if.sv
design/gihd_out_if.sv
design/gihd_line_store.sv
design/gihd_raster.sv
design/gray_image_half_downsample_unit.sv
tb/tb.sv
